### rtl/jsu_pkg.sv
// Shared types, character codes and helpers for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

  localparam int MAX_BURST = 6;

  localparam logic [7:0]  CH_NUL    = 8'h00;
  localparam logic [7:0]  CH_QUOTE  = 8'h22;
  localparam logic [7:0]  CH_BSLASH = 8'h5C;
  localparam logic [7:0]  CH_U      = 8'h75;

  localparam logic [15:0] SURR_HIGH_FIRST = 16'hD800;
  localparam logic [15:0] SURR_HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] SURR_LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] SURR_LOW_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;

  localparam logic [11:0] MAX_OUT_RESET = 12'd1032;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic       last_of_run;
  } out_t;

  // All results caused by one input byte.
  typedef struct packed {
    logic [MAX_BURST-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      has_byte;
    logic                      str_end;
  } burst_t;

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_ESC,
    MODE_HEX,
    MODE_PAIR_BS,
    MODE_PAIR_U,
    MODE_LOW
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_START,
    ACT_ESC,
    ACT_U_START,
    ACT_NUL_CP,
    ACT_FINISH,
    ACT_COMBINE
  } act_t;

  // Value 16 flags a non-hex byte.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] d;
    d = 5'd16;
    if (b >= 8'h30 && b <= 8'h39) d = 5'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) d = 5'(b - 8'h57);
    else if (b >= 8'h41 && b <= 8'h46) d = 5'(b - 8'h37);
    return d;
  endfunction

endpackage

### rtl/jsu_front.sv
// Front end: decoder state, escape classification and UTF-8 burst build.
`timescale 1ns / 1ps

module jsu_front
  import jsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  in_t         in_data,
  input  logic [11:0] max_out_bytes,
  output logic        push,
  output burst_t      push_data
);

  typedef struct packed {
    logic [MAX_BURST-1:0][7:0] bytes;
    logic [2:0]                n;
    logic [11:0]               bo;
  } work_t;

  function automatic work_t emit1(input work_t w, input logic [7:0] b);
    work_t r;
    r = w;
    if (r.n < 3'(MAX_BURST)) begin
      r.bytes[r.n] = b;
      r.n = r.n + 3'd1;
    end
    if (r.bo != 12'hFFF) r.bo = r.bo + 12'd1;
    return r;
  endfunction

  function automatic work_t emit_cp(input work_t w, input logic [20:0] cp);
    work_t r;
    r = w;
    if (cp < 21'h80) begin
      r = emit1(r, cp[7:0]);
    end else if (cp < 21'h800) begin
      r = emit1(r, {3'b110, cp[10:6]});
      r = emit1(r, {2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      r = emit1(r, {4'b1110, cp[15:12]});
      r = emit1(r, {2'b10, cp[11:6]});
      r = emit1(r, {2'b10, cp[5:0]});
    end else begin
      r = emit1(r, {5'b11110, cp[20:18]});
      r = emit1(r, {2'b10, cp[17:12]});
      r = emit1(r, {2'b10, cp[11:6]});
      r = emit1(r, {2'b10, cp[5:0]});
    end
    return r;
  endfunction

  mode_t       mode;
  logic [15:0] hex_value;
  logic [15:0] low_value;
  logic [2:0]  hex_count;
  logic        hex_stopped;
  logic [15:0] pending_high;
  logic [11:0] bytes_out;
  logic        ended;

  mode_t       mode_next;
  logic [15:0] hex_value_next;
  logic [15:0] low_value_next;
  logic [2:0]  hex_count_next;
  logic        hex_stopped_next;
  logic [15:0] pending_high_next;
  logic        ended_next;
  logic        ended_start;

  work_t       w;
  act_t        act;
  logic        flush;
  logic        do_start;
  logic        do_esc;
  logic        low;
  logic [15:0] acc;
  logic [20:0] cp;
  logic [4:0]  d;
  logic [7:0]  b;

  always_comb begin
    mode_next         = mode;
    hex_value_next    = hex_value;
    low_value_next    = low_value;
    hex_count_next    = hex_count;
    hex_stopped_next  = hex_stopped;
    pending_high_next = pending_high;
    ended_next        = ended;
    w                 = '0;
    w.bo              = bytes_out;
    act               = ACT_NONE;
    flush             = 1'b0;
    do_start          = 1'b0;
    do_esc            = 1'b0;
    cp                = '0;
    b                 = in_data.in_byte;
    d                 = hex_digit(b);

    if (in_data.first_byte) begin
      mode_next         = MODE_NORMAL;
      hex_value_next    = '0;
      low_value_next    = '0;
      hex_count_next    = '0;
      hex_stopped_next  = 1'b0;
      pending_high_next = '0;
      w.bo              = '0;
      ended_next        = 1'b0;
    end
    ended_start = ended_next;
    low = (mode_next == MODE_LOW);
    acc = low ? low_value_next : hex_value_next;

    // classify
    if (!ended_next) begin
      case (mode_next)
        MODE_NORMAL: act = ACT_START;
        MODE_ESC:    act = ACT_ESC;
        MODE_PAIR_BS: begin
          if (b == CH_BSLASH) begin
            mode_next = MODE_PAIR_U;
          end else begin
            flush = 1'b1;
            act   = ACT_START;
          end
        end
        MODE_PAIR_U: begin
          if (b == CH_U) begin
            mode_next        = MODE_LOW;
            hex_value_next   = '0;
            low_value_next   = '0;
            hex_count_next   = '0;
            hex_stopped_next = 1'b0;
          end else begin
            flush = 1'b1;
            act   = ACT_ESC;
          end
        end
        MODE_HEX, MODE_LOW: begin
          if (hex_count_next == 3'd0 && d[4]) begin
            flush = low;
            act   = ACT_U_START;
          end else if (b == CH_NUL) begin
            flush = low;
            act   = ACT_NUL_CP;
            cp    = {5'd0, acc};
          end else begin
            if (!hex_stopped_next && !d[4]) acc = {acc[11:0], d[3:0]};
            else hex_stopped_next = 1'b1;
            if (low) low_value_next = acc;
            else hex_value_next = acc;
            hex_count_next = hex_count_next + 3'd1;
            if (hex_count_next[2]) begin
              if (low && !hex_stopped_next && acc >= SURR_LOW_FIRST &&
                  acc <= SURR_LOW_LAST) begin
                act = ACT_COMBINE;
                cp  = SUPPLEMENTARY_BASE + {1'b0, pending_high_next[9:0], acc[9:0]};
              end else begin
                flush = low;
                act   = ACT_FINISH;
                cp    = {5'd0, acc};
              end
            end
          end
        end
        default: act = ACT_NONE;
      endcase
    end

    // carry out
    if (flush) begin
      w = emit_cp(w, {5'd0, pending_high_next});
      pending_high_next = '0;
      mode_next = MODE_NORMAL;
      if (w.bo >= max_out_bytes) ended_next = 1'b1;
    end

    if (!ended_next) begin
      case (act)
        ACT_START: do_start = 1'b1;
        ACT_ESC:   do_esc = 1'b1;
        ACT_U_START: begin
          w = emit1(w, CH_U);
          mode_next = MODE_NORMAL;
          if (w.bo >= max_out_bytes) ended_next = 1'b1;
          do_start = !ended_next;
        end
        ACT_NUL_CP: begin
          w = emit_cp(w, cp);
          mode_next  = MODE_NORMAL;
          ended_next = 1'b1;
        end
        ACT_FINISH: begin
          if (cp[15:0] >= SURR_HIGH_FIRST && cp[15:0] <= SURR_HIGH_LAST) begin
            pending_high_next = cp[15:0];
            mode_next = MODE_PAIR_BS;
          end else begin
            w = emit_cp(w, cp);
            mode_next = MODE_NORMAL;
            if (w.bo >= max_out_bytes) ended_next = 1'b1;
          end
        end
        ACT_COMBINE: begin
          pending_high_next = '0;
          w = emit_cp(w, cp);
          mode_next = MODE_NORMAL;
          if (w.bo >= max_out_bytes) ended_next = 1'b1;
        end
        default: ;
      endcase
    end

    if (do_start) begin
      mode_next = MODE_NORMAL;
      if (w.bo >= max_out_bytes || b == CH_NUL || b == CH_QUOTE) begin
        ended_next = 1'b1;
      end else if (b == CH_BSLASH) begin
        mode_next = MODE_ESC;
      end else begin
        w = emit1(w, b);
        if (w.bo >= max_out_bytes) ended_next = 1'b1;
      end
    end

    if (do_esc) begin
      if (b == CH_NUL) begin
        w = emit1(w, CH_BSLASH);
        mode_next  = MODE_NORMAL;
        ended_next = 1'b1;
      end else if (b == CH_U) begin
        mode_next        = MODE_HEX;
        hex_value_next   = '0;
        low_value_next   = '0;
        hex_count_next   = '0;
        hex_stopped_next = 1'b0;
      end else begin
        w = emit1(w, b);
        mode_next = MODE_NORMAL;
        if (w.bo >= max_out_bytes) ended_next = 1'b1;
      end
    end

    push               = accept && !ended_start && (w.n != 3'd0 || ended_next);
    push_data.bytes    = w.bytes;
    push_data.count    = (w.n == 3'd0) ? 3'd1 : w.n;
    push_data.has_byte = (w.n != 3'd0);
    push_data.str_end  = ended_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_NORMAL;
      hex_value    <= '0;
      low_value    <= '0;
      hex_count    <= '0;
      hex_stopped  <= 1'b0;
      pending_high <= '0;
      bytes_out    <= '0;
      ended        <= 1'b0;
    end else if (accept) begin
      mode         <= mode_next;
      hex_value    <= hex_value_next;
      low_value    <= low_value_next;
      hex_count    <= hex_count_next;
      hex_stopped  <= hex_stopped_next;
      pending_high <= pending_high_next;
      bytes_out    <= w.bo;
      ended        <= ended_next;
    end
  end

endmodule

### rtl/jsu_queue.sv
// Burst queue between the front end and the output serializer.
`timescale 1ns / 1ps

module jsu_queue
  import jsu_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  burst_t push_data,
  input  logic   pop,
  output logic   full,
  output logic   empty,
  output burst_t head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  burst_t        entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

### rtl/jsu_back.sv
// Back end: serializes each burst into output transactions.
`timescale 1ns / 1ps

module jsu_back
  import jsu_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   q_empty,
  input  burst_t head,
  output logic   pop,
  output logic   out_valid,
  input  logic   out_stall,
  output out_t   out_data
);

  logic [2:0] idx;
  logic       load;
  logic       last;

  assign load = !q_empty && (!out_valid || !out_stall);
  assign last = (idx == head.count - 3'd1);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) out_valid <= !q_empty;
      if (load) idx <= last ? 3'd0 : idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.out_byte    <= head.has_byte ? head.bytes[idx] : 8'd0;
      out_data.byte_valid  <= head.has_byte;
      out_data.string_end  <= last && head.str_end;
      out_data.last_of_run <= last;
    end
  end

endmodule

### rtl/json_string_unescape_utf8_core.sv
// Top level of the JSON string unescaper with UTF-8 output.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------
//   input    | in_valid / in_stall  | in_data  (in_byte, first_byte)
//   output   | out_valid / out_stall| out_data (out_byte, byte_valid,
//            |                      |   string_end, last_of_run)
//   config   | cfg_we               | cfg_data (max_out_bytes)
//
// One input byte per cycle while the queue has room; a byte that yields k
// results (k up to 6) has them presented one by one by the serializer.
// The first result passes through the queue and then the output register.
// The queue holds QDEPTH bursts; in_stall is high while it is full.
// Synchronous reset clears decoder state, queue and output valid.
`timescale 1ns / 1ps

module json_string_unescape_utf8_core
  import jsu_pkg::*;
#(
  parameter int QDEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [11:0] cfg_data
);

  logic [11:0] max_out_bytes;
  logic        accept;
  logic        push;
  burst_t      push_data;
  logic        pop;
  logic        q_full;
  logic        q_empty;
  burst_t      head;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) max_out_bytes <= MAX_OUT_RESET;
    else if (cfg_we) max_out_bytes <= cfg_data;
  end

  jsu_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .in_data       (in_data),
    .max_out_bytes (max_out_bytes),
    .push          (push),
    .push_data     (push_data)
  );

  jsu_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/jsu_checker.sv
// Port-level assertions for the unescaper, bound to the top level.
`timescale 1ns / 1ps

module jsu_checker
  import jsu_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input out_t        out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.string_end |-> out_data.last_of_run)
    else $error("string_end on a result that is not last");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_valid |->
      out_data.string_end && out_data.out_byte == 8'd0)
    else $error("byteless result that does not end the string");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind json_string_unescape_utf8_core jsu_checker u_jsu_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
